// ===== design/lru_pkg.sv =====
// Shared types and constants for the LRU page replacement block.
`default_nettype none

package lru_pkg;

  localparam int FRAME_COUNT_DEF = 8;
  localparam int PAGE_BITS_DEF   = 16;

  localparam int IN_PAGE_W   = 16;
  localparam int FRAME_IDX_W = 3;
  localparam int TOTAL_W     = 32;
  localparam int CFG_W       = 4;
  localparam int CFG_MAX     = (1 << CFG_W) - 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } lru_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decide;
    logic commit;
  } lru_cmd_t;

endpackage

`default_nettype wire

// ===== design/lru_ctrl.sv =====
// Controller: sequences capture, lookup decision and commit of each item.
`default_nettype none

module lru_ctrl
  import lru_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output lru_cmd_t      cmd
);

  lru_state_t state_r;
  lru_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // next item may be taken while this one commits
        if (start) state_nxt = ST_EVAL;
        else       state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.decide  = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = start;
      end
      ST_EVAL: begin
        busy       = 1'b1;
        cmd.decide = 1'b1;
      end
      ST_COMMIT: begin
        cmd.capture = start;
        cmd.commit  = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_EVAL))
    else $error("accepted item did not enter lookup");

  a_eval_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |=> cmd.commit)
    else $error("lookup not followed by commit");

  a_commit_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $past(cmd.decide))
    else $error("commit without a preceding lookup");
`endif

endmodule

`default_nettype wire

// ===== design/lru_dpath.sv =====
// Datapath: frame tags, recency ranks, victim choice, totals and result registers.
`default_nettype none

module lru_dpath
  import lru_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF
)
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lru_cmd_t               cmd,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data,
  input  wire logic [IN_PAGE_W-1:0]   in_page_number,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [FRAME_IDX_W-1:0]      out_frame_index,
  output logic                        out_evicted_valid,
  output logic [IN_PAGE_W-1:0]        out_evicted_page,
  output logic [TOTAL_W-1:0]          out_hit_total,
  output logic [TOTAL_W-1:0]          out_miss_total
);

  // frames past the largest register value are never managed, so not built
  localparam int LANES = (FRAME_COUNT < CFG_MAX) ? FRAME_COUNT : CFG_MAX;
  localparam int IW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int RW    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  localparam logic [RW-1:0]    RANK_SAT  = RW'(FRAME_COUNT - 1);
  localparam logic [RW:0]      LIMIT_ALL = (RW + 1)'(FRAME_COUNT);
  localparam logic [CFG_W-1:0] LANES_CFG = CFG_W'(LANES);

  logic [CFG_W-1:0]     cfg_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] frame_page_r [LANES];
  logic [RW-1:0]        frame_rank_r [LANES];
  logic [TOTAL_W-1:0]   hit_count_r;
  logic [TOTAL_W-1:0]   miss_count_r;
  logic [TOTAL_W-1:0]   hit_count_nxt;
  logic [TOTAL_W-1:0]   miss_count_nxt;

  // decision stage
  logic                 dec_zero_r;
  logic                 dec_hit_r;
  logic                 dec_ev_r;
  logic [IW-1:0]        dec_f_r;
  logic [RW:0]          dec_limit_r;
  logic [PAGE_BITS-1:0] dec_ev_page_r;

  logic                 dec_zero_nxt;
  logic                 dec_hit_nxt;
  logic                 dec_ev_nxt;
  logic [IW-1:0]        dec_f_nxt;
  logic [RW:0]          dec_limit_nxt;
  logic [PAGE_BITS-1:0] dec_ev_page_nxt;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [FRAME_IDX_W-1:0] out_frame_index_r;
  logic                 out_ev_r;
  logic [IN_PAGE_W-1:0] out_ev_page_r;

  logic [CFG_W-1:0]     managed;
  logic [LANES-1:0]     lane_on;
  logic [31:0]          page_wide;
  logic [31:0]          f_wide;
  logic [31:0]          ev_wide;

  assign managed = (cfg_r == '0)       ? CFG_W'(1) :
                   (cfg_r > LANES_CFG) ? LANES_CFG : cfg_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_on[i] = (CFG_W'(i) < managed);
    end
  end

  assign page_wide = {{(32 - IN_PAGE_W){1'b0}}, in_page_number};
  assign f_wide    = 32'(dec_f_r);
  assign ev_wide   = 32'(dec_ev_page_r);

  // lookup: first matching frame, else first empty frame, else oldest frame
  always_comb begin
    logic          hit_found;
    logic          empty_found;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] empty_idx;
    logic [IW-1:0] vic_idx;
    logic [RW-1:0] best;
    hit_found   = 1'b0;
    empty_found = 1'b0;
    hit_idx     = '0;
    empty_idx   = '0;
    vic_idx     = '0;
    best        = '0;
    for (int i = 0; i < LANES; i++) begin
      if (lane_on[i] && !hit_found && frame_page_r[i] == page_r) begin
        hit_found = 1'b1;
        hit_idx   = IW'(i);
      end
      if (lane_on[i] && !empty_found && frame_page_r[i] == '0) begin
        empty_found = 1'b1;
        empty_idx   = IW'(i);
      end
      if (lane_on[i] && frame_rank_r[i] > best) begin
        best    = frame_rank_r[i];
        vic_idx = IW'(i);
      end
    end

    dec_zero_nxt    = (page_r == '0);
    dec_hit_nxt     = 1'b0;
    dec_ev_nxt      = 1'b0;
    dec_f_nxt       = '0;
    dec_limit_nxt   = '0;
    dec_ev_page_nxt = '0;
    if (!dec_zero_nxt) begin
      if (hit_found) begin
        dec_hit_nxt   = 1'b1;
        dec_f_nxt     = hit_idx;
        dec_limit_nxt = {1'b0, frame_rank_r[hit_idx]};
      end else if (empty_found) begin
        dec_f_nxt     = empty_idx;
        dec_limit_nxt = LIMIT_ALL;
      end else begin
        dec_ev_nxt      = 1'b1;
        dec_f_nxt       = vic_idx;
        dec_limit_nxt   = {1'b0, best};
        dec_ev_page_nxt = frame_page_r[vic_idx];
      end
    end
  end

  always_comb begin
    hit_count_nxt  = hit_count_r;
    miss_count_nxt = miss_count_r;
    if (!dec_zero_r) begin
      if (dec_hit_r) begin
        if (hit_count_r != '1) hit_count_nxt = hit_count_r + TOTAL_W'(1);
      end else begin
        if (miss_count_r != '1) miss_count_nxt = miss_count_r + TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= CFG_RESET;
      hit_count_r  <= '0;
      miss_count_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        frame_page_r[i] <= '0;
        frame_rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      out_valid_r <= cmd.commit;
      if (cmd.commit && !dec_zero_r) begin
        hit_count_r  <= hit_count_nxt;
        miss_count_r <= miss_count_nxt;
        for (int i = 0; i < LANES; i++) begin
          if (IW'(i) == dec_f_r) begin
            frame_rank_r[i] <= '0;
            if (!dec_hit_r) frame_page_r[i] <= page_r;
          end else if (lane_on[i] && frame_page_r[i] != '0 &&
                       {1'b0, frame_rank_r[i]} < dec_limit_r &&
                       frame_rank_r[i] < RANK_SAT) begin
            frame_rank_r[i] <= frame_rank_r[i] + RW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) page_r <= page_wide[PAGE_BITS-1:0];
    if (cmd.decide) begin
      dec_zero_r    <= dec_zero_nxt;
      dec_hit_r     <= dec_hit_nxt;
      dec_ev_r      <= dec_ev_nxt;
      dec_f_r       <= dec_f_nxt;
      dec_limit_r   <= dec_limit_nxt;
      dec_ev_page_r <= dec_ev_page_nxt;
    end
    if (cmd.commit) begin
      out_hit_r         <= dec_hit_r;
      out_frame_index_r <= f_wide[FRAME_IDX_W-1:0];
      out_ev_r          <= dec_ev_r;
      out_ev_page_r     <= ev_wide[IN_PAGE_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_index_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_hit_total     = hit_count_r;
  assign out_miss_total    = miss_count_r;

`ifndef SYNTHESIS
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evicted_valid)
    else $error("hit item reported an eviction");

  a_evict_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted_valid) |-> (out_evicted_page != '0))
    else $error("evicted an empty frame");

  a_used_frame_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !dec_zero_r) |=> (frame_rank_r[$past(dec_f_r)] == '0))
    else $error("used frame not most recent after commit");
`endif

endmodule

`default_nettype wire

// ===== design/lru_page_replacement.sv =====
// Top level of the LRU page replacement block.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | start / busy        | in_page_number
//  result   | out_valid (strobe)  | out_hit, out_frame_index, out_evicted_valid,
//           |                     | out_evicted_page, out_hit_total, out_miss_total
//  config   | cfg_wr_en           | cfg_wr_data (frames in use)
//
// An item passes through a lookup state (tag compare, empty and oldest-frame
// search) and a commit state (rank, tag and total update); the next item is
// taken during the commit state. busy is high in the lookup state only.
// The result strobe comes in the cycle after commit, for one cycle.
// Synchronous reset empties all frames, clears ranks and totals, frames in use = 4.
// The receiver cannot stall; results are never held.
`default_nettype none

module lru_page_replacement
  import lru_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF
)
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [IN_PAGE_W-1:0]   in_page_number,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [FRAME_IDX_W-1:0]      out_frame_index,
  output logic                        out_evicted_valid,
  output logic [IN_PAGE_W-1:0]        out_evicted_page,
  output logic [TOTAL_W-1:0]          out_hit_total,
  output logic [TOTAL_W-1:0]          out_miss_total
);

  lru_cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lru_dpath #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BITS   (PAGE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total)
  );

endmodule

`default_nettype wire

// ===== tb/sv/lru_page_checker.sv =====
// Checker for the LRU page replacement block: recency predictor and result scoreboard.
module lru_page_checker
  import lru_pkg::*;
#(
  parameter int FRAMES = FRAME_COUNT_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [IN_PAGE_W-1:0]   in_page_number,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic                   out_valid,
  input  logic                   out_hit,
  input  logic [FRAME_IDX_W-1:0] out_frame_index,
  input  logic                   out_evicted_valid,
  input  logic [IN_PAGE_W-1:0]   out_evicted_page,
  input  logic [TOTAL_W-1:0]     out_hit_total,
  input  logic [TOTAL_W-1:0]     out_miss_total,
  output int                     outstanding,
  output int                     error_count
);

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    logic                   ev_valid;
    logic [IN_PAGE_W-1:0]   ev_page;
    logic [TOTAL_W-1:0]     hits;
    logic [TOTAL_W-1:0]     misses;
  } page_outcome_t;

  logic [IN_PAGE_W-1:0]   resident [FRAMES];
  logic [FRAME_IDX_W-1:0] age [FRAMES];
  logic [TOTAL_W-1:0]     hit_tally;
  logic [TOTAL_W-1:0]     miss_tally;
  logic [CFG_W-1:0]       frames_cfg;
  page_outcome_t          awaited_outcomes [$];
  int                     errs;

  initial begin
    outstanding = 0;
    error_count = 0;
    errs        = 0;
  end

  // Frame f becomes youngest; occupied managed frames younger than limit age by one.
  task automatic make_youngest(input int n, input int f, input int limit);
    for (int i = 0; i < n; i++) begin
      if (i != f && resident[i] != '0 && int'(age[i]) < limit && int'(age[i]) < FRAMES - 1)
        age[i] = age[i] + 1'b1;
    end
    age[f] = '0;
  endtask

  task automatic reference_page(input logic [IN_PAGE_W-1:0] page, output page_outcome_t r);
    int  n;
    int  f;
    int  best;
    bit  found;
    n = int'(frames_cfg);
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    r = '0;
    f = 0;
    found = 1'b0;
    if (page != '0) begin
      for (int i = 0; i < n && !found; i++)
        if (resident[i] == page) begin
          f = i;
          found = 1'b1;
        end
      if (found) begin
        r.hit = 1'b1;
        make_youngest(n, f, int'(age[f]));
        if (hit_tally != '1) hit_tally = hit_tally + 1'b1;
      end else begin
        for (int i = 0; i < n && !found; i++)
          if (resident[i] == '0) begin
            f = i;
            found = 1'b1;
          end
        if (found) begin
          resident[f] = page;
          make_youngest(n, f, FRAMES);
        end else begin
          // oldest managed frame, lowest index on a tie
          best = 0;
          f = 0;
          for (int i = 0; i < n; i++)
            if (int'(age[i]) > best) begin
              best = int'(age[i]);
              f = i;
            end
          r.ev_valid = 1'b1;
          r.ev_page  = resident[f];
          resident[f] = page;
          make_youngest(n, f, best);
        end
        if (miss_tally != '1) miss_tally = miss_tally + 1'b1;
      end
    end
    r.frame  = f[FRAME_IDX_W-1:0];
    r.hits   = hit_tally;
    r.misses = miss_tally;
  endtask

  task automatic compare_field(input string name, input logic [TOTAL_W-1:0] exp_v,
                               input logic [TOTAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    page_outcome_t got;
    page_outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) begin
        resident[i] = '0;
        age[i]      = '0;
      end
      hit_tally  = '0;
      miss_tally = '0;
      frames_cfg = CFG_RESET;
      awaited_outcomes.delete();
    end else begin
      if (out_valid) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none actual page frame %0d",
                   $time, out_frame_index);
          errs++;
        end else begin
          want = awaited_outcomes.pop_front();
          compare_field("hit", want.hit, out_hit);
          compare_field("frame_index", want.frame, out_frame_index);
          compare_field("evicted_valid", want.ev_valid, out_evicted_valid);
          compare_field("evicted_page", want.ev_page, out_evicted_page);
          compare_field("hit_total", want.hits, out_hit_total);
          compare_field("miss_total", want.misses, out_miss_total);
        end
      end
      if (cfg_wr_en) frames_cfg = cfg_wr_data;
      if (start && !busy) begin
        reference_page(in_page_number, got);
        awaited_outcomes.push_back(got);
      end
    end
    outstanding <= awaited_outcomes.size();
    error_count <= errs;
  end

endmodule

// ===== tb/sv/lru_page_replacement_tb.sv =====
// Testbench top for the LRU page replacement block: stimulus, reset and verdict.
module lru_page_replacement_tb;
  import lru_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [IN_PAGE_W-1:0]   in_page_number = '0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   out_valid;
  logic                   out_hit;
  logic [FRAME_IDX_W-1:0] out_frame_index;
  logic                   out_evicted_valid;
  logic [IN_PAGE_W-1:0]   out_evicted_page;
  logic [TOTAL_W-1:0]     out_hit_total;
  logic [TOTAL_W-1:0]     out_miss_total;
  int                     outstanding;
  int                     error_count;

  int                     burst_left = 0;
  logic [IN_PAGE_W-1:0]   page_pool [12];
  int                     pool_size;

  always #4 clk = ~clk;

  lru_page_replacement uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total)
  );

  lru_page_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total),
    .outstanding       (outstanding),
    .error_count       (error_count)
  );

  // back-to-back bursts now and then, otherwise a uniformly drawn idle gap before each item
  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
    return $urandom_range(0, 13);
  endfunction

  // start stays high across back-to-back items
  task automatic send_page(input logic [IN_PAGE_W-1:0] page);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_page_number <= page;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // checker count is registered, so read it only from the edge after the last item
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] value, input int count);
    int managed;
    int pick;
    write_frames(value);
    managed = (value == 0) ? 1 : (int'(value) > FRAME_COUNT_DEF ? FRAME_COUNT_DEF : int'(value));
    // keep the old pool half the time so frames hidden by a shrink get hit again
    if ($urandom_range(0, 1) == 1) begin
      for (int i = 0; i < 12; i++) page_pool[i] = IN_PAGE_W'($urandom_range(1, 65535));
    end
    pool_size = managed + $urandom_range(0, 3);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) send_page(page_pool[$urandom_range(0, pool_size - 1)]);
      else if (pick < 78) send_page('0);
      else send_page(IN_PAGE_W'($urandom_range(1, 65535)));
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin
    for (int i = 0; i < 12; i++) page_pool[i] = IN_PAGE_W'($urandom_range(1, 65535));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting of four frames: fill, ignored zero page, hits, evictions
    send_page(16'd1);
    send_page(16'd2);
    send_page(16'd3);
    send_page(16'd4);
    send_page(16'd0);
    send_page(16'd3);
    send_page(16'hFFFF);
    send_page(16'h8000);
    send_page(16'd4);
    send_page(16'h00FF);
    send_page(16'hFFFF);
    send_page(16'd1);
    write_frames(4'd8);
    send_page(16'hAAAA);
    send_page(16'h5555);
    send_page(16'd2);
    write_frames(4'd1);
    send_page(16'h1234);
    send_page(16'h1234);
    send_page(16'hAAAA);
    write_frames(4'd0);
    send_page(16'd7);
    send_page(16'd7);
    write_frames(4'd15);
    send_page(16'h5555);
    send_page(16'hAAAA);

    random_phase(4'd8, 110);
    random_phase(4'd2, 100);
    random_phase(4'd8, 110);
    random_phase(4'd15, 100);
    random_phase(4'd5, 100);
    random_phase(4'd0, 90);
    random_phase(4'd3, 100);
    random_phase(4'd9, 110);
    random_phase(4'd6, 100);
    random_phase(4'd1, 90);
    random_phase(4'd7, 120);
    random_phase(4'd4, 120);

    drain();
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
design/lru_pkg.sv
design/lru_ctrl.sv
design/lru_dpath.sv
design/lru_page_replacement.sv
tb/sv/lru_page_checker.sv
tb/sv/lru_page_replacement_tb.sv
